// File: sv/otsu_pkg.sv
// ----------------------------------------------------------------------------
// otsu_pkg
// Shared constants, command/status types and encodings of the Otsu binarizer.
// ----------------------------------------------------------------------------
`default_nettype none

package otsu_pkg;

  // Default frame limit and histogram size
  localparam int unsigned MAX_PIXELS_DEF  = 1048575;
  localparam int unsigned GRAY_LEVELS_DEF = 256;

  // Luma weights 0.298912, 0.586611, 0.114478 scaled by 2^16
  localparam logic [15:0] LUMA_R = 16'd19590;
  localparam logic [15:0] LUMA_G = 16'd38444;
  localparam logic [15:0] LUMA_B = 16'd7502;

  // Bits of the multiplier operand retired per cycle
  localparam int unsigned MUL_DIGIT_W = 4;

  // Result kinds
  localparam logic KIND_THRESH = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  // Pass selection on the input beat
  localparam logic MODE_HIST = 1'b0;

  // Product being formed by the shared multiplier
  typedef enum logic [2:0] {
    MUL_P   = 3'd0,  // s1 * n2
    MUL_Q   = 3'd1,  // s2 * n1
    MUL_DEN = 3'd2,  // n1 * n2
    MUL_DSQ = 3'd3,  // d * d
    MUL_LHS = 3'd4,  // d^2 * best_den
    MUL_RHS = 3'd5   // best_d^2 * den
  } mul_sel_e;

  typedef struct packed {
    logic     hist_wr;
    logic     out_pix;
    logic     out_rep;
    logic     srch_init;
    logic     srch_rd;
    logic     srch_acc;
    logic     mul_start;
    logic     mul_store;
    mul_sel_e mul_sel;
    logic     t_inc;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic hist_mode;
    logic last;
    logic sat;
    logic out_free;
    logic t_zero;
    logic t_last;
    logic split_ok;
  } dp_status_t;

endpackage

`default_nettype wire

// File: sv/otsu_if.sv
// ----------------------------------------------------------------------------
// otsu_if
// Valid/ready channels for pixel input beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface otsu_pix_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;

  modport source (output valid, output mode, output red, output green, output blue,
                  output last_pixel, input ready);
  modport sink (input valid, input mode, input red, input green, input blue,
                input last_pixel, output ready);
endinterface

interface otsu_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] threshold;
  logic [7:0] gray_level;
  logic       pixel_on;

  modport source (output valid, output result_kind, output threshold, output gray_level,
                  output pixel_on, input ready);
  modport sink (input valid, input result_kind, input threshold, input gray_level,
                input pixel_on, output ready);
endinterface

`default_nettype wire

// File: sv/otsu_ram.sv
// ----------------------------------------------------------------------------
// otsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module otsu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/otsu_mul.sv
// ----------------------------------------------------------------------------
// otsu_mul
// Iterative unsigned multiplier, one digit of the b operand per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module otsu_mul
  import otsu_pkg::*;
#(
  parameter int unsigned AW = 96,
  parameter int unsigned BW = 48
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output      logic             busy_o,
  output      logic             done_o,
  output      logic [AW+BW-1:0] prod_o
);

  localparam int unsigned ProdW = AW + BW;
  localparam int unsigned Steps = (BW + MUL_DIGIT_W - 1) / MUL_DIGIT_W;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [ProdW-1:0] a_sh_q, acc_q, pp;
  logic [BW-1:0]    b_sh_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;

  assign pp = a_sh_q * b_sh_q[MUL_DIGIT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_sh_q <= ProdW'(a_i);
      b_sh_q <= b_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      acc_q  <= acc_q + pp;
      a_sh_q <= a_sh_q << MUL_DIGIT_W;
      b_sh_q <= b_sh_q >> MUL_DIGIT_W;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

// File: sv/otsu_ctrl.sv
// ----------------------------------------------------------------------------
// otsu_ctrl
// Sequencer for histogram update, binarize output and the threshold search.
// ----------------------------------------------------------------------------
`default_nettype none

module otsu_ctrl
  import otsu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_accept_i,
  input  wire dp_status_t status_i,
  output      logic       in_ready_o,
  output      dp_cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b00000000001,
    ST_PIX   = 11'b00000000010,
    ST_HWR   = 11'b00000000100,
    ST_SINIT = 11'b00000001000,
    ST_STEP  = 11'b00000010000,
    ST_SACC  = 11'b00000100000,
    ST_SCHK  = 11'b00001000000,
    ST_MST   = 11'b00010000000,
    ST_MWT   = 11'b00100000000,
    ST_SNEXT = 11'b01000000000,
    ST_FIN   = 11'b10000000000
  } state_e;

  state_e   state_q, state_d;
  mul_sel_e sel_q, sel_d;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.mul_sel = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept_i) state_d = ST_PIX;
      end
      ST_PIX: begin
        if (!status_i.hist_mode) begin
          if (status_i.out_free) begin
            cmd_o.out_pix = 1'b1;
            state_d       = ST_IDLE;
          end
        end else if (!status_i.sat) begin
          state_d = ST_HWR;
        end else begin
          state_d = status_i.last ? ST_SINIT : ST_IDLE;
        end
      end
      ST_HWR: begin
        cmd_o.hist_wr = 1'b1;
        state_d       = status_i.last ? ST_SINIT : ST_IDLE;
      end
      ST_SINIT: begin
        cmd_o.srch_init = 1'b1;
        state_d         = ST_STEP;
      end
      ST_STEP: begin
        if (status_i.t_zero) begin
          state_d = ST_SCHK;
        end else begin
          cmd_o.srch_rd = 1'b1;
          state_d       = ST_SACC;
        end
      end
      ST_SACC: begin
        cmd_o.srch_acc = 1'b1;
        state_d        = ST_SCHK;
      end
      ST_SCHK: begin
        if (status_i.split_ok) begin
          sel_d   = MUL_P;
          state_d = ST_MST;
        end else begin
          state_d = ST_SNEXT;
        end
      end
      ST_MST: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_MWT;
      end
      ST_MWT: begin
        if (status_i.mul_done) begin
          cmd_o.mul_store = 1'b1;
          case (sel_q)
            MUL_P:   begin sel_d = MUL_Q;   state_d = ST_MST; end
            MUL_Q:   begin sel_d = MUL_DEN; state_d = ST_MST; end
            MUL_DEN: begin sel_d = MUL_DSQ; state_d = ST_MST; end
            MUL_DSQ: begin sel_d = MUL_LHS; state_d = ST_MST; end
            MUL_LHS: begin sel_d = MUL_RHS; state_d = ST_MST; end
            default: state_d = ST_SNEXT;
          endcase
        end
      end
      ST_SNEXT: begin
        if (status_i.t_last) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.t_inc = 1'b1;
          state_d     = ST_STEP;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.out_rep = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= MUL_P;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire

// File: sv/otsu_dp.sv
// ----------------------------------------------------------------------------
// otsu_dp
// Datapath: gray conversion, histogram store, search registers, result slot.
// ----------------------------------------------------------------------------
`default_nettype none

module otsu_dp
  import otsu_pkg::*;
#(
  parameter int unsigned MaxPixels  = MAX_PIXELS_DEF,
  parameter int unsigned GrayLevels = GRAY_LEVELS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_accept_i,
  input  wire logic       mode_i,
  input  wire logic [7:0] red_i,
  input  wire logic [7:0] green_i,
  input  wire logic [7:0] blue_i,
  input  wire logic       last_i,
  input  wire dp_cmd_t    cmd_i,
  output      dp_status_t status_o,
  output      logic       res_valid_o,
  input  wire logic       res_ready_i,
  output      logic       res_kind_o,
  output      logic [7:0] res_thr_o,
  output      logic [7:0] res_gray_o,
  output      logic       res_on_o
);

  localparam int unsigned CntW  = $clog2(MaxPixels + 1);
  localparam int unsigned BinW  = $clog2(GrayLevels);
  localparam int unsigned SumW  = CntW + BinW;
  localparam int unsigned PW    = SumW + CntW;
  localparam int unsigned DenW  = 2 * CntW;
  localparam int unsigned DsqW  = 2 * PW;
  localparam int unsigned LhsW  = DsqW + DenW;
  localparam int unsigned MulAW = DsqW;
  localparam int unsigned MulBW = PW;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned GxW   = (BinW > 8) ? BinW : 8;

  // Captured input beat
  logic       mode_q, last_q;
  logic [7:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      mode_q  <= mode_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      last_q  <= last_i;
    end
  end

  // Gray level and histogram bin
  logic [23:0]     luma;
  logic [7:0]      gray;
  logic [GxW-1:0]  gray_ext;
  logic [BinW-1:0] bin;

  assign luma     = 24'(LUMA_R) * 24'(red_q) + 24'(LUMA_G) * 24'(green_q)
                  + 24'(LUMA_B) * 24'(blue_q);
  assign gray     = luma[23:16];
  assign gray_ext = GxW'(gray);
  assign bin      = (gray_ext > GxW'(GrayLevels - 1)) ? BinW'(GrayLevels - 1)
                                                       : gray_ext[BinW-1:0];

  // Frame totals and chosen threshold
  logic [CntW-1:0] total_q;
  logic [SumW-1:0] sum_q;
  logic [7:0]      chosen_q;

  // Histogram store with per-bin valid bits
  logic [GrayLevels-1:0] bin_vld_q;
  logic                  rd_vld_q;
  logic [BinW-1:0]       raddr, tm1;
  logic [CntW-1:0]       rdata, hist_val;

  // Search registers
  logic [BinW-1:0]  t_q, best_t_q;
  logic [CntW-1:0]  n1_q, n2;
  logic [SumW-1:0]  s1_q, s2;
  logic [PW-1:0]    p_q, d_q, qv;
  logic [DenW-1:0]  den_q, best_den_q;
  logic [DsqW-1:0]  dsq_q, best_dsq_q;
  logic [LhsW-1:0]  lhs_q;
  logic [GxW-1:0]   best_t_ext;

  assign tm1      = t_q - 1'b1;
  assign raddr    = cmd_i.srch_rd ? tm1 : bin;
  assign hist_val = rd_vld_q ? rdata : '0;
  assign n2       = total_q - n1_q;
  assign s2       = sum_q - s1_q;
  assign best_t_ext = GxW'(best_t_q);

  otsu_ram #(
    .Width (CntW),
    .Depth (GrayLevels)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (cmd_i.hist_wr),
    .waddr_i (bin),
    .wdata_i (hist_val + 1'b1),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Shared multiplier
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [ProdW-1:0] prod;
  logic             mul_busy, mul_done;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_P:   begin mul_a = MulAW'(s1_q);       mul_b = MulBW'(n2);         end
      MUL_Q:   begin mul_a = MulAW'(s2);         mul_b = MulBW'(n1_q);       end
      MUL_DEN: begin mul_a = MulAW'(n1_q);       mul_b = MulBW'(n2);         end
      MUL_DSQ: begin mul_a = MulAW'(d_q);        mul_b = d_q;                end
      MUL_LHS: begin mul_a = dsq_q;              mul_b = MulBW'(best_den_q); end
      default: begin mul_a = best_dsq_q;         mul_b = MulBW'(den_q);      end
    endcase
  end

  otsu_mul #(
    .AW (MulAW),
    .BW (MulBW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign qv = prod[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_init) begin
      t_q        <= '0;
      n1_q       <= '0;
      s1_q       <= '0;
      best_dsq_q <= '0;
      best_den_q <= DenW'(1);
      best_t_q   <= '0;
    end
    if (cmd_i.t_inc) t_q <= t_q + 1'b1;
    if (cmd_i.srch_acc) begin
      n1_q <= n1_q + hist_val;
      s1_q <= s1_q + SumW'(hist_val) * SumW'(tm1);
    end
    if (cmd_i.mul_store) begin
      case (cmd_i.mul_sel)
        MUL_P:   p_q   <= qv;
        MUL_Q:   d_q   <= (p_q > qv) ? p_q - qv : qv - p_q;
        MUL_DEN: den_q <= prod[DenW-1:0];
        MUL_DSQ: dsq_q <= prod[DsqW-1:0];
        MUL_LHS: lhs_q <= prod[LhsW-1:0];
        default: begin
          // strictly greater only, so ties keep the lower threshold
          if (lhs_q > prod[LhsW-1:0]) begin
            best_dsq_q <= dsq_q;
            best_den_q <= den_q;
            best_t_q   <= t_q;
          end
        end
      endcase
    end
  end

  // Histogram state and threshold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      total_q   <= '0;
      sum_q     <= '0;
      chosen_q  <= '0;
    end else begin
      rd_vld_q <= bin_vld_q[raddr];
      if (cmd_i.hist_wr) begin
        bin_vld_q[bin] <= 1'b1;
        total_q        <= total_q + 1'b1;
        sum_q          <= sum_q + SumW'(bin);
      end
      if (cmd_i.out_rep) begin
        bin_vld_q <= '0;
        total_q   <= '0;
        sum_q     <= '0;
        chosen_q  <= best_t_ext[7:0];
      end
    end
  end

  // Result slot
  logic       rvalid_q, kind_q, on_q;
  logic [7:0] thr_q, gray_q;
  logic       out_free;

  assign out_free = !rvalid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else if (cmd_i.out_pix || cmd_i.out_rep) begin
      rvalid_q <= 1'b1;
    end else if (res_ready_i) begin
      rvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_pix) begin
      kind_q <= KIND_PIXEL;
      thr_q  <= chosen_q;
      gray_q <= gray;
      on_q   <= (gray >= chosen_q);
    end else if (cmd_i.out_rep) begin
      kind_q <= KIND_THRESH;
      thr_q  <= best_t_ext[7:0];
      gray_q <= '0;
      on_q   <= 1'b0;
    end
  end

  assign res_valid_o = rvalid_q;
  assign res_kind_o  = kind_q;
  assign res_thr_o   = thr_q;
  assign res_gray_o  = gray_q;
  assign res_on_o    = on_q;

  assign status_o.mul_done  = mul_done;
  assign status_o.hist_mode = (mode_q == MODE_HIST) && !mul_busy;
  assign status_o.last      = last_q;
  assign status_o.sat       = (total_q == CntW'(MaxPixels));
  assign status_o.out_free  = out_free;
  assign status_o.t_zero    = (t_q == '0);
  assign status_o.t_last    = (t_q == BinW'(GrayLevels - 1));
  assign status_o.split_ok  = (n1_q != '0) && (n2 != '0);

endmodule

`default_nettype wire

// File: sv/otsu_threshold_binarize_top.sv
// ----------------------------------------------------------------------------
// otsu_threshold_binarize_top
// Two-pass Otsu thresholding and binarization of an RGB pixel stream.
// ----------------------------------------------------------------------------
// Each pixel beat is turned into an 8-bit gray level with 16-bit fixed-point
// luma weights. Histogram-pass beats (mode 0) are counted into a GrayLevels-bin
// histogram held in a RAM; they give no result beat, except the beat flagged
// last_pixel, which starts the threshold search and yields one threshold
// report. Binarize-pass beats (mode 1) give one result beat each: the gray
// level, the current threshold and whether gray >= threshold. Items are taken
// one at a time: a binarize beat occupies the block through capture and the
// result load, a histogram beat through capture, bin lookup in the RAM and
// write-back of the incremented count. The search walks the thresholds one by
// one; each level but the first costs a bin read and, where both classes are
// non-empty, six products formed one after another on a single iterative
// multiplier retiring 4 operand bits per cycle, whose b operand is PW =
// 2*ceil(log2(MaxPixels+1)) + ceil(log2(GrayLevels)) bits wide. Input is held
// off during the search. A result waits in an output register, so the next
// pixel is taken while it is pending. Counts stop at MaxPixels. The histogram
// is cleared at once by per-bin valid bits, at reset and after every search;
// no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module otsu_threshold_binarize_top
  import otsu_pkg::*;
#(
  parameter int unsigned MaxPixels  = MAX_PIXELS_DEF,
  parameter int unsigned GrayLevels = GRAY_LEVELS_DEF
) (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  otsu_pix_if.sink   pix_i,
  otsu_res_if.source res_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;
  logic       in_accept;

  // An input beat lands only while the sequencer sits idle
  assign pix_i.ready = in_ready;
  assign in_accept   = pix_i.valid && in_ready;

  otsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .status_i    (status),
    .in_ready_o  (in_ready),
    .cmd_o       (cmd)
  );

  otsu_dp #(
    .MaxPixels  (MaxPixels),
    .GrayLevels (GrayLevels)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .mode_i      (pix_i.mode),
    .red_i       (pix_i.red),
    .green_i     (pix_i.green),
    .blue_i      (pix_i.blue),
    .last_i      (pix_i.last_pixel),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_kind_o  (res_o.result_kind),
    .res_thr_o   (res_o.threshold),
    .res_gray_o  (res_o.gray_level),
    .res_on_o    (res_o.pixel_on)
  );

  // Never overwrite a result beat still waiting downstream
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_pix || cmd.out_rep) |-> status.out_free)
    else $error("result register loaded while occupied");

  // A report load shows up as a threshold beat next cycle
  a_report_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_rep |=> (res_o.valid && res_o.result_kind == KIND_THRESH))
    else $error("threshold report missing");

  // One item at a time: intake drops right after a beat
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !pix_i.ready)
    else $error("second beat taken while busy");

  // Stores only on a multiplier completion
  a_store_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_store |-> status.mul_done)
    else $error("product stored before completion");

endmodule

`default_nettype wire

// File: sim/otsu_threshold_binarize_top_test.sv
// ----------------------------------------------------------------------------
// otsu_threshold_binarize_top_test
// Self-checking bench for the two-pass Otsu thresholder and binarizer.
// ----------------------------------------------------------------------------
// Pixel frames are streamed in the histogram pass and then in the binarize
// pass. A scoreboard keeps its own histogram, repeats the exact Otsu search on
// every last-pixel histogram beat, checks each result beat field by field; both
// channels idle at random, with one stretch of frames where neither side idles.
// ----------------------------------------------------------------------------
`default_nettype none

class otsu_scoreboard;
  typedef struct packed {
    logic       kind;
    logic [7:0] thr;
    logic [7:0] gray;
    logic       on;
  } otsu_res_t;

  otsu_res_t   pending_q[$];
  logic [19:0] hist_bins[256];
  logic [19:0] pix_count;
  logic [27:0] level_sum;
  logic [7:0]  cur_thr;
  int          fails;

  function new();
    foreach (hist_bins[i]) hist_bins[i] = '0;
    pix_count = '0;
    level_sum = '0;
    cur_thr   = '0;
    fails     = 0;
  endfunction

  static function logic [7:0] luma(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [31:0] acc;
    acc = otsu_pkg::LUMA_R * r + otsu_pkg::LUMA_G * g + otsu_pkg::LUMA_B * b;
    return acc[23:16];
  endfunction

  // exact between-class search; ties keep the lowest level
  function logic [7:0] search_threshold();
    logic [63:0]  n1, s1, n2, s2, p, q, d, den, best_d, best_den;
    logic [191:0] lhs, rhs, w_d, w_bd, w_den, w_bden;
    logic [7:0]   best_t;
    n1 = 0; s1 = 0; best_d = 0; best_den = 1; best_t = 0;
    for (int t = 0; t < 256; t++) begin
      if (t > 0) begin
        n1 += hist_bins[t-1];
        s1 += 64'(hist_bins[t-1]) * 64'(t - 1);
      end
      n2 = (pix_count >= n1) ? pix_count - n1 : 0;
      s2 = (level_sum >= s1) ? level_sum - s1 : 0;
      if (n1 != 0 && n2 != 0) begin
        p = s1 * n2;
        q = s2 * n1;
        d = (p > q) ? p - q : q - p;
        den = n1 * n2;
        w_d = d; w_bd = best_d; w_den = den; w_bden = best_den;
        lhs = w_d * w_d * w_bden;
        rhs = w_bd * w_bd * w_den;
        if (lhs > rhs) begin
          best_d = d;
          best_den = den;
          best_t = 8'(t);
        end
      end
    end
    return best_t;
  endfunction

  function void note_pixel(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic last);
    logic [7:0] gray;
    otsu_res_t  e;
    gray = luma(r, g, b);
    if (mode != otsu_pkg::MODE_HIST) begin
      e = '{otsu_pkg::KIND_PIXEL, cur_thr, gray, gray >= cur_thr};
      pending_q.push_back(e);
      return;
    end
    if (pix_count < otsu_pkg::MAX_PIXELS_DEF) begin
      hist_bins[gray]++;
      pix_count++;
      level_sum += gray;
    end
    if (!last) return;
    cur_thr = search_threshold();
    foreach (hist_bins[i]) hist_bins[i] = '0;
    pix_count = '0;
    level_sum = '0;
    e = '{otsu_pkg::KIND_THRESH, cur_thr, 8'd0, 1'b0};
    pending_q.push_back(e);
  endfunction

  function void check_result(logic kind, logic [7:0] thr, logic [7:0] gray, logic on);
    otsu_res_t e;
    if (pending_q.size() == 0) begin
      $error("unexpected result beat kind=%0d thr=%0d", kind, thr);
      fails++;
      return;
    end
    e = pending_q.pop_front();
    if (kind !== e.kind) begin
      $error("result_kind exp %0d got %0d", e.kind, kind); fails++;
    end
    if (thr !== e.thr) begin
      $error("threshold exp %0d got %0d", e.thr, thr); fails++;
    end
    if (gray !== e.gray) begin
      $error("gray_level exp %0d got %0d", e.gray, gray); fails++;
    end
    if (on !== e.on) begin
      $error("pixel_on exp %0d got %0d", e.on, on); fails++;
    end
  endfunction
endclass

module otsu_threshold_binarize_top_test;
  import otsu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 100000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic quiet = 1'b0;       // no idling on either side while set
  int   stall_cycles = 0;
  int   items_sent = 0;

  otsu_pix_if pix ();
  otsu_res_if res ();

  otsu_scoreboard sb = new();

  otsu_threshold_binarize_top u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix),
    .res_o (res)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    pix.valid = 1'b0;
    pix.mode = 1'b0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    pix.last_pixel = 1'b0;
    res.ready = 1'b0;
  end

  // Result side: stall about one cycle in five, check every accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res.valid && res.ready)
        sb.check_result(res.result_kind, res.threshold, res.gray_level, res.pixel_on);
      res.ready <= quiet || ($urandom_range(99) >= 20);
    end
  end

  // Watchdog: a search holds input off, so the limit is on cycles without any
  // accepted beat, not on total run length.
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Drive one beat; valid is raised or kept high with a single assignment, and
  // random idle cycles go in front of it.
  task automatic send_pix(logic mode, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                          logic last);
    while (!quiet && $urandom_range(99) < 20) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.mode <= mode;
    pix.red <= r;
    pix.green <= g;
    pix.blue <= b;
    pix.last_pixel <= last;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    sb.note_pixel(mode, r, g, b, last);
    items_sent++;
  endtask

  task automatic release_pix();
    pix.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Clustered color: near one of two centers, or anywhere at all.
  function automatic logic [7:0] pick_chan(logic [7:0] c0, logic [7:0] c1);
    int v;
    if ($urandom_range(9) < 3) return 8'($urandom_range(255));
    v = ($urandom_range(1) ? int'(c1) : int'(c0)) + $urandom_range(16) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  task automatic random_frame();
    logic [7:0] c0, c1;
    int hist_n, bin_n;
    c0 = 8'($urandom_range(255));
    c1 = 8'($urandom_range(255));
    hist_n = $urandom_range(3, 60);
    bin_n = $urandom_range(10, 60);
    for (int i = 0; i < hist_n; i++)
      send_pix(MODE_HIST, pick_chan(c0, c1), pick_chan(c0, c1), pick_chan(c0, c1),
               i == hist_n - 1);
    for (int i = 0; i < bin_n; i++) begin
      // stray last_pixel on a binarize beat must be ignored
      send_pix(~MODE_HIST, pick_chan(c0, c1), pick_chan(c0, c1), pick_chan(c0, c1),
               1'($urandom_range(9) == 0));
    end
  endtask

  initial begin
    int frames;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Binarize before any search: threshold is the reset value.
    send_pix(~MODE_HIST, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pix(~MODE_HIST, 8'd255, 8'd255, 8'd255, 1'b1);
    // Single-pixel frame, uniform: threshold stays 0.
    send_pix(MODE_HIST, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pix(~MODE_HIST, 8'd128, 8'd0, 8'd0, 1'b0);
    // Uniform multi-pixel frame.
    repeat (3) send_pix(MODE_HIST, 8'd90, 8'd90, 8'd90, 1'b0);
    send_pix(MODE_HIST, 8'd90, 8'd90, 8'd90, 1'b1);
    // Black, white and the pure primaries.
    send_pix(MODE_HIST, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pix(MODE_HIST, 8'd255, 8'd0, 8'd0, 1'b0);
    send_pix(MODE_HIST, 8'd0, 8'd255, 8'd0, 1'b0);
    send_pix(MODE_HIST, 8'd0, 8'd0, 8'd255, 1'b0);
    send_pix(MODE_HIST, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pix(~MODE_HIST, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pix(~MODE_HIST, 8'd255, 8'd0, 8'd0, 1'b0);
    send_pix(~MODE_HIST, 8'd0, 8'd255, 8'd0, 1'b0);
    send_pix(~MODE_HIST, 8'd0, 8'd0, 8'd255, 1'b1);
    send_pix(~MODE_HIST, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pix(~MODE_HIST, 8'd85, 8'd170, 8'd51, 1'b0);

    // Random frames, with one stretch where neither side idles.
    frames = 0;
    while (items_sent < 2000) begin
      quiet <= (frames >= 6 && frames < 9);
      random_frame();
      frames++;
    end
    quiet <= 1'b0;
    release_pix();

    // Drain and let the block settle; the watchdog bounds the wait.
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.fails == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

`default_nettype wire

// File: filelist.f
sv/otsu_pkg.sv
sv/otsu_if.sv
sv/otsu_ram.sv
sv/otsu_mul.sv
sv/otsu_ctrl.sv
sv/otsu_dp.sv
sv/otsu_threshold_binarize_top.sv
sim/otsu_threshold_binarize_top_test.sv
